@@ hw/rtl/cbiq_pkg.sv @@
// ----------------------------------------------------------------------------
// cbiq_pkg
// Shared constants, command types and saturation helpers for the cascaded
// biquad filter.
// ----------------------------------------------------------------------------
package cbiq_pkg;

	localparam int SECTIONS = 2;
	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	// sections whose coefficient register the configuration port can write
	localparam int COEF_REGS = (SECTIONS < 2) ? SECTIONS : 2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEC_ONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEC_TWO = 2'd2;

	localparam logic [31:0] GAIN_RESET = 32'h1000_0000;

	localparam int PROD_W = 48;
	localparam int ACC_W = 50;

	typedef enum logic [2:0] {
		MUL_GAIN,
		MUL_C0H1,
		MUL_C1H2,
		MUL_C2H1,
		MUL_C3H2
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_GAIN,
		ACC_INIT_V,
		ACC_INIT_NH,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		V_HOLD,
		V_GAIN,
		V_SECTION
	} v_op_t;

	typedef struct packed {
		logic             load_sample;
		mul_sel_t         mul_sel;
		acc_op_t          acc_op;
		v_op_t            v_op;
		logic             hist_shift;
		logic             out_load;
		logic [SEC_W-1:0] sec;
	} cbiq_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
		logic signed [31:0] r;
		if (x > 36'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -36'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [24:0] x);
		logic signed [15:0] r;
		if (x > 25'sd32767) begin
			r = 16'sh7FFF;
		end else if (x < -25'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/cbiq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbiq_ctrl
// Sequencer: walks the gain step and each section over the shared
// multiply-accumulate datapath, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module cbiq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output cbiq_pkg::cbiq_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_GMUL,
		S_GACC,
		S_GV,
		S_M0,
		S_M1,
		S_A1,
		S_NH,
		S_M3,
		S_A3,
		S_V,
		S_OUT
	} state_t;

	state_t                     state_q;
	logic [cbiq_pkg::SEC_W-1:0] sec_q;
	logic                       out_valid_q;
	logic                       out_free;

	localparam logic [cbiq_pkg::SEC_W-1:0] LAST_SEC = cbiq_pkg::SEC_W'(cbiq_pkg::SECTIONS - 1);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sec_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_GMUL;
					end
				end
				S_GMUL: state_q <= S_GACC;
				S_GACC: state_q <= S_GV;
				S_GV: begin
					sec_q   <= '0;
					state_q <= S_M0;
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_A1;
				S_A1: state_q <= S_NH;
				S_NH: state_q <= S_M3;
				S_M3: state_q <= S_A3;
				S_A3: state_q <= S_V;
				S_V: begin
					if (sec_q == LAST_SEC) begin
						state_q <= S_OUT;
					end else begin
						sec_q   <= sec_q + 1'b1;
						state_q <= S_M0;
					end
				end
				S_OUT: begin
					// wait until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.mul_sel     = cbiq_pkg::MUL_GAIN;
		cmd.acc_op      = cbiq_pkg::ACC_HOLD;
		cmd.v_op        = cbiq_pkg::V_HOLD;
		cmd.sec         = sec_q;
		cmd.load_sample = in_valid && (state_q == S_IDLE);
		case (state_q)
			S_GMUL: cmd.mul_sel = cbiq_pkg::MUL_GAIN;
			S_GACC: cmd.acc_op = cbiq_pkg::ACC_LOAD_GAIN;
			S_GV:   cmd.v_op = cbiq_pkg::V_GAIN;
			S_M0: begin
				cmd.mul_sel = cbiq_pkg::MUL_C0H1;
				cmd.acc_op  = cbiq_pkg::ACC_INIT_V;
			end
			S_M1: begin
				cmd.mul_sel = cbiq_pkg::MUL_C1H2;
				cmd.acc_op  = cbiq_pkg::ACC_SUB;
			end
			S_A1:   cmd.acc_op = cbiq_pkg::ACC_SUB;
			S_NH: begin
				cmd.mul_sel = cbiq_pkg::MUL_C2H1;
				cmd.acc_op  = cbiq_pkg::ACC_INIT_NH;
			end
			S_M3: begin
				cmd.mul_sel = cbiq_pkg::MUL_C3H2;
				cmd.acc_op  = cbiq_pkg::ACC_ADD;
			end
			S_A3:   cmd.acc_op = cbiq_pkg::ACC_ADD;
			S_V: begin
				cmd.v_op       = cbiq_pkg::V_SECTION;
				cmd.hist_shift = 1'b1;
			end
			S_OUT:  cmd.out_load = out_free;
			default: cmd.acc_op = cbiq_pkg::ACC_HOLD;
		endcase
	end

endmodule

@@ hw/rtl/cbiq_datapath.sv @@
// ----------------------------------------------------------------------------
// cbiq_datapath
// Configuration registers, section history, one 32x16 multiplier with a
// product register, a 50-bit accumulator and the rounding/saturation logic.
// ----------------------------------------------------------------------------
module cbiq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbiq_pkg::cbiq_cmd_t                 cmd,
	input  logic                                cfg_valid,
	input  logic [cbiq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [63:0]                         cfg_data,
	input  logic signed [15:0]                  sample_in,
	output logic signed [15:0]                  sample_out
);

	localparam logic signed [cbiq_pkg::ACC_W-1:0] RND14 = 50'sd8192;
	localparam logic signed [cbiq_pkg::ACC_W-1:0] RND20 = 50'sd524288;

	logic signed [31:0]                 gain_q;
	logic [63:0]                        coef_q [cbiq_pkg::SECTIONS];
	logic signed [31:0]                 hist_q [cbiq_pkg::SECTIONS][2];

	logic signed [15:0]                 sample_q;
	logic signed [cbiq_pkg::PROD_W-1:0] prod_q;
	logic signed [cbiq_pkg::ACC_W-1:0]  acc_q;
	logic signed [31:0]                 v_q;
	logic signed [31:0]                 nh_q;
	logic signed [15:0]                 out_q;

	logic [63:0]                        row;
	logic signed [31:0]                 h1;
	logic signed [31:0]                 h2;
	logic signed [31:0]                 mul_a;
	logic signed [15:0]                 mul_b;
	logic signed [cbiq_pkg::PROD_W-1:0] prod;
	logic signed [cbiq_pkg::ACC_W-1:0]  prod_ext;
	logic signed [cbiq_pkg::ACC_W-1:0]  acc_shr14;
	logic signed [cbiq_pkg::ACC_W-1:0]  acc_shr20;
	logic signed [31:0]                 nh;
	logic signed [32:0]                 v_rnd;
	logic signed [32:0]                 v_shr8;

	assign row = coef_q[cmd.sec];
	assign h1  = hist_q[cmd.sec][0];
	assign h2  = hist_q[cmd.sec][1];

	always_comb begin
		case (cmd.mul_sel)
			cbiq_pkg::MUL_GAIN: begin
				mul_a = gain_q;
				mul_b = sample_q;
			end
			cbiq_pkg::MUL_C0H1: begin
				mul_a = h1;
				mul_b = row[15:0];
			end
			cbiq_pkg::MUL_C1H2: begin
				mul_a = h2;
				mul_b = row[31:16];
			end
			cbiq_pkg::MUL_C2H1: begin
				mul_a = h1;
				mul_b = row[47:32];
			end
			cbiq_pkg::MUL_C3H2: begin
				mul_a = h2;
				mul_b = row[63:48];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod      = mul_a * mul_b;
	assign prod_ext  = {{(cbiq_pkg::ACC_W - cbiq_pkg::PROD_W){prod_q[cbiq_pkg::PROD_W-1]}}, prod_q};
	assign acc_shr14 = acc_q >>> 14;
	assign acc_shr20 = acc_q >>> 20;
	assign nh        = cbiq_pkg::sat32(acc_shr14[35:0]);
	assign v_rnd     = {v_q[31], v_q} + 33'sd128;
	assign v_shr8    = v_rnd >>> 8;
	assign sample_out = out_q;

	// configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= cbiq_pkg::GAIN_RESET;
			for (int s = 0; s < cbiq_pkg::SECTIONS; s++) begin
				coef_q[s]    <= '0;
				hist_q[s][0] <= '0;
				hist_q[s][1] <= '0;
			end
		end else begin
			if (cfg_valid && (cfg_index == cbiq_pkg::REG_GAIN)) begin
				gain_q <= cfg_data[31:0];
			end
			for (int s = 0; s < cbiq_pkg::COEF_REGS; s++) begin
				if (cfg_valid && (cfg_index == cbiq_pkg::CFG_IDX_W'(s + 1))) begin
					coef_q[s] <= cfg_data;
				end
			end
			if (cmd.hist_shift) begin
				hist_q[cmd.sec][1] <= hist_q[cmd.sec][0];
				hist_q[cmd.sec][0] <= nh_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample_in;
		end
		prod_q <= prod;
		case (cmd.acc_op)
			cbiq_pkg::ACC_LOAD_GAIN: acc_q <= prod_ext + RND20;
			cbiq_pkg::ACC_INIT_V: begin
				acc_q <= ({{(cbiq_pkg::ACC_W - 32){v_q[31]}}, v_q} <<< 14) + RND14;
			end
			cbiq_pkg::ACC_INIT_NH: begin
				// new history becomes the base of the section output sum
				nh_q  <= nh;
				acc_q <= ({{(cbiq_pkg::ACC_W - 32){nh[31]}}, nh} <<< 14) + RND14;
			end
			cbiq_pkg::ACC_ADD: acc_q <= acc_q + prod_ext;
			cbiq_pkg::ACC_SUB: acc_q <= acc_q - prod_ext;
			default: acc_q <= acc_q;
		endcase
		case (cmd.v_op)
			cbiq_pkg::V_GAIN:    v_q <= acc_shr20[31:0];
			cbiq_pkg::V_SECTION: v_q <= nh;
			default:             v_q <= v_q;
		endcase
		if (cmd.out_load) begin
			out_q <= cbiq_pkg::sat16(v_shr8[24:0]);
		end
	end

endmodule

@@ hw/rtl/cascaded_biquad_iir_filter.sv @@
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter
// Fixed-point gain stage followed by a cascade of direct form II biquad
// sections, computed on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A new input word is taken only in idle, once the previous word has been
// loaded into the output register; the single multiplier does the gain
// product and four products per section.
// reset: history cleared, gain 1.0, coefficients zero, output empty
module cascaded_biquad_iir_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [15:0]             sample_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [15:0]             sample_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cbiq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);

	cbiq_pkg::cbiq_cmd_t cmd;

	assign cfg_ready = 1'b1;

	cbiq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	cbiq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a word is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output register overwritten before it was taken");

	a_hist_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_shift |-> !in_ready)
		else $error("history shifted while idle");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("output valid without a result load");

endmodule
